[src/hgcd_pkg.sv]
// hgcd_pkg: shared widths, constants, datapath structs and the CORDIC
// arctangent table of the haversine distance pipeline.
// No dependencies.
`default_nettype none

package hgcd_pkg;

  // port field widths
  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int DIST_W = 25;

  // internal widths
  localparam int ANGLE_W  = 30;   // half-angle difference or doubled latitude
  localparam int MAG_W    = 28;   // folded angle magnitude, up to a quarter turn
  localparam int QUO_W    = 23;   // magnitude / 45
  localparam int RAD_W    = 32;   // radians Q30, signed
  localparam int CORDIC_W = 34;   // CORDIC x, y, z
  localparam int TRIG_W   = 32;   // sin / cos Q30, signed
  localparam int Q60_W    = 61;   // a in Q60, 0 .. 2^60
  localparam int ROOT_W   = 31;   // floor sqrt of a Q60 value
  localparam int REM_W    = 61;

  localparam int unsigned CORDIC_ITERATIONS_DEF = 24;

  // angle units are 2^-21 degree
  localparam logic [ANGLE_W-1:0] FULL_TURN          = 30'd754974720;
  localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 30'd566231040;
  localparam logic [ANGLE_W-1:0] HALF_TURN          = 30'd377487360;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 30'd188743680;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [CORDIC_W-1:0] GAIN_INV_Q30 = 34'd652032874;

  // QUARTER_TURN = 45 * 2^22: divide by 45 through reciprocals
  localparam logic [28:0] RECIP45       = 29'd381774871;  // ceil(2^34 / 45)
  localparam int          RECIP45_SH    = 34;
  localparam logic [15:0] RECIP45_N     = 16'd46604;      // ceil(2^21 / 45)
  localparam int          RECIP45_N_SH  = 21;
  localparam logic [36:0] ROUND_HALF_Q  = 37'd94371840;   // 45 * 2^21

  localparam logic [13:0] DIAMETER_KM = 14'd12742;
  localparam logic [Q60_W-1:0] ONE_Q60 = 61'h1000000000000000;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [CORDIC_W-1:0] atan_q30(input int unsigned idx);
    logic [CORDIC_W-1:0] v;
    case (idx)
      0:       v = 34'h03243F6A8;
      1:       v = 34'h01DAC6705;
      2:       v = 34'h00FADBAFC;
      3:       v = 34'h007F56EA6;
      4:       v = 34'h003FEAB76;
      5:       v = 34'h001FFD55B;
      6:       v = 34'h000FFFAAA;
      7:       v = 34'h0007FFF55;
      8:       v = 34'h0003FFFEA;
      9:       v = 34'h0001FFFFD;
      10:      v = 34'h0000FFFFF;
      11:      v = 34'h00007FFFF;
      12:      v = 34'h00003FFFF;
      13:      v = 34'h00001FFFF;
      14:      v = 34'h00000FFFF;
      15:      v = 34'h000007FFF;
      16:      v = 34'h000003FFF;
      17:      v = 34'h000001FFF;
      18:      v = 34'h000000FFF;
      19:      v = 34'h0000007FF;
      20:      v = 34'h0000003FF;
      21:      v = 34'h0000001FF;
      22:      v = 34'h0000000FF;
      23:      v = 34'h00000007F;
      24:      v = 34'h00000003F;
      25:      v = 34'h00000001F;
      26:      v = 34'h00000000F;
      27:      v = 34'h000000007;
      28:      v = 34'h000000003;
      29:      v = 34'h000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[src/hgcd_rad.sv]
// hgcd_rad: wraps an angle to one turn, folds it into +-90 degrees and
// scales it to radians Q30 with rounding, six register stages.
// Depends on hgcd_pkg.
`default_nettype none

module hgcd_rad (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [hgcd_pkg::ANGLE_W-1:0] angle_i,
  output logic signed [hgcd_pkg::RAD_W-1:0]   rad_o,
  output logic                               flip_o
);
  import hgcd_pkg::*;

  logic [ANGLE_W-1:0] wrap_nxt, wrap_r;
  logic [ANGLE_W-1:0] d_half_lo, d_half_hi, d_full;
  logic [MAG_W-1:0]   mag_nxt, mag_r, mag3_r;
  logic               neg_nxt, flip_nxt;
  logic [3:0]         neg_r, flip_r;
  logic [56:0]        quo_prod;
  logic [QUO_W-1:0]   quo_r;
  logic [MAG_W-1:0]   q45;
  logic [5:0]         rem_nxt, rem_r;
  logic [53:0]        ahl_nxt, ahl_r;
  logic [36:0]        frac_sum;
  logic [14:0]        frac_r;
  logic [RAD_W-1:0]   hi_r;
  logic [30:0]        corr_prod;
  logic [RAD_W-1:0]   mag_rad;
  logic signed [RAD_W-1:0] rad_nxt, rad_r;

  // wrap into [0, full turn)
  assign wrap_nxt = angle_i[ANGLE_W-1] ? angle_i + FULL_TURN : angle_i;

  // fold into +-quarter turn; crossing a quarter turn negates the cosine
  always_comb begin
    d_half_lo = HALF_TURN - wrap_r;
    d_half_hi = wrap_r - HALF_TURN;
    d_full    = FULL_TURN - wrap_r;
    if (wrap_r <= QUARTER_TURN) begin
      mag_nxt = wrap_r[MAG_W-1:0];
      neg_nxt = 1'b0;
      flip_nxt = 1'b0;
    end else if (wrap_r < HALF_TURN) begin
      mag_nxt = d_half_lo[MAG_W-1:0];
      neg_nxt = 1'b0;
      flip_nxt = 1'b1;
    end else if (wrap_r < THREE_QUARTER_TURN) begin
      mag_nxt = d_half_hi[MAG_W-1:0];
      neg_nxt = 1'b1;
      flip_nxt = 1'b1;
    end else begin
      mag_nxt = d_full[MAG_W-1:0];
      neg_nxt = 1'b1;
      flip_nxt = 1'b0;
    end
  end

  // round(mag * HALF_PI / (45 * 2^22)), split as mag = 45*quo + rem
  assign quo_prod = mag_r * RECIP45;

  always_comb begin
    q45      = MAG_W'(quo_r) * MAG_W'(45);
    rem_nxt  = 6'(mag3_r - q45);
    ahl_nxt  = quo_r * HALF_PI_Q30;
    frac_sum = 37'(ahl_r[21:0]) * 37'd45 + 37'(rem_r) * 37'(HALF_PI_Q30) + ROUND_HALF_Q;
    corr_prod = frac_r * RECIP45_N;
    mag_rad  = hi_r + RAD_W'(corr_prod[30:RECIP45_N_SH]);
    rad_nxt  = neg_r[3] ? -$signed(mag_rad) : $signed(mag_rad);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrap_r    <= wrap_nxt;
      mag_r     <= mag_nxt;
      neg_r     <= {neg_r[2:0], neg_nxt};
      flip_r    <= {flip_r[2:0], flip_nxt};
      quo_r     <= quo_prod[56:RECIP45_SH];
      mag3_r    <= mag_r;
      rem_r     <= rem_nxt;
      ahl_r     <= ahl_nxt;
      frac_r    <= frac_sum[36:22];
      hi_r      <= ahl_r[53:22];
      rad_r     <= rad_nxt;
    end
  end

  // flip/neg line: stage 2 enters bit 0, output stage reads bit 3
  logic flip_out_r;
  always_ff @(posedge clk) begin
    if (en) flip_out_r <= flip_r[3];
  end

  assign rad_o  = rad_r;
  assign flip_o = flip_out_r;

endmodule

`default_nettype wire

[src/hgcd_cordic_cell.sv]
// hgcd_cordic_cell: one registered CORDIC micro-rotation, rotation or
// vectoring mode, fixed shift per cell.
// Depends on hgcd_pkg.
`default_nettype none

module hgcd_cordic_cell #(
  parameter int unsigned STAGE     = 0,
  parameter bit          VECTORING = 1'b0
) (
  input  logic              clk,
  input  logic              en,
  input  hgcd_pkg::cordic_t cell_i,
  output hgcd_pkg::cordic_t cell_o
);
  import hgcd_pkg::*;

  logic signed [CORDIC_W-1:0] x_sh, y_sh, ang;
  logic    ccw;
  cordic_t cell_nxt, cell_r;

  always_comb begin
    x_sh = $signed(cell_i.x) >>> STAGE;
    y_sh = $signed(cell_i.y) >>> STAGE;
    ang  = $signed(atan_q30(STAGE));
    // rotation steers on z, vectoring drives y toward zero
    ccw  = VECTORING ? cell_i.y[CORDIC_W-1] : ~cell_i.z[CORDIC_W-1];
    if (ccw) begin
      cell_nxt.x = $signed(cell_i.x) - y_sh;
      cell_nxt.y = $signed(cell_i.y) + x_sh;
      cell_nxt.z = $signed(cell_i.z) - ang;
    end else begin
      cell_nxt.x = $signed(cell_i.x) + y_sh;
      cell_nxt.y = $signed(cell_i.y) - x_sh;
      cell_nxt.z = $signed(cell_i.z) + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) cell_r <= cell_nxt;
  end

  assign cell_o = cell_r;

endmodule

`default_nettype wire

[src/hgcd_sqrt_cell.sv]
// hgcd_sqrt_cell: one registered digit of a restoring integer square root,
// deciding result bit BIT.
// Depends on hgcd_pkg.
`default_nettype none

module hgcd_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk,
  input  logic            en,
  input  hgcd_pkg::sqrt_t cell_i,
  output hgcd_pkg::sqrt_t cell_o
);
  import hgcd_pkg::*;

  localparam int TW = REM_W + 1;

  logic [TW-1:0] trial;
  sqrt_t         cell_nxt, cell_r;

  // (root + 2^BIT)^2 - root^2
  always_comb begin
    trial = (TW'(cell_i.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    cell_nxt = cell_i;
    if ({1'b0, cell_i.rem} >= trial) begin
      cell_nxt.rem  = cell_i.rem - trial[REM_W-1:0];
      cell_nxt.root = cell_i.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) cell_r <= cell_nxt;
  end

  assign cell_o = cell_r;

endmodule

`default_nettype wire

[src/haversine_great_circle_distance_top.sv]
// CORDIC_ITERATIONS sets both CORDIC chain lengths; counts above 32 act as 32.
// Throughput: one word per cycle unless out_stall holds the pipeline;
// every stage is a register cell in a chain.
// Reset (rst_n low, synchronous) clears only the valid line and out_valid.
// Depends on hgcd_pkg, hgcd_rad, hgcd_cordic_cell, hgcd_sqrt_cell.
`default_nettype none

module haversine_great_circle_distance_top #(
  parameter int unsigned CORDIC_ITERATIONS = hgcd_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [hgcd_pkg::LAT_W-1:0]    in_first_latitude,
  input  logic signed [hgcd_pkg::LON_W-1:0]    in_first_longitude,
  input  logic signed [hgcd_pkg::LAT_W-1:0]    in_second_latitude,
  input  logic signed [hgcd_pkg::LON_W-1:0]    in_second_longitude,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hgcd_pkg::DIST_W-1:0]          out_distance_km
);
  import hgcd_pkg::*;

  // iteration counts above 32 add nothing: the table and shifts run out
  localparam int N = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
  // input, diff, 6 radian stages, N rotations, 4 product stages,
  // ROOT_W root digits, N vectoring steps (output register not counted)
  localparam int PIPE_DEPTH = 2 * N + 12 + ROOT_W;
  localparam int A_STAGE    = N + 10;   // stage holding clamped a

  // Whole pipeline advances together; the output register parts the sides,
  // so a new word enters whenever the result slot is free or being taken.
  logic en;
  assign en       = ~out_valid_r | ~out_stall;
  assign in_stall = ~en;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  // ---- input word
  logic signed [LAT_W-1:0] lat1_r, lat2_r;
  logic signed [LON_W-1:0] lon1_r, lon2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= in_first_latitude;
      lon1_r <= in_first_longitude;
      lat2_r <= in_second_latitude;
      lon2_r <= in_second_longitude;
    end
  end

  // ---- angles in 2^-21 degree: differences are already half angles,
  //      latitudes enter doubled
  logic signed [ANGLE_W-1:0] ang_nxt [0:3];
  logic signed [ANGLE_W-1:0] ang_r   [0:3];

  always_comb begin
    ang_nxt[0] = ANGLE_W'(lat2_r) - ANGLE_W'(lat1_r);
    ang_nxt[1] = ANGLE_W'(lon2_r) - ANGLE_W'(lon1_r);
    ang_nxt[2] = ANGLE_W'(lat1_r) <<< 1;
    ang_nxt[3] = ANGLE_W'(lat2_r) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) ang_r[i] <= ang_nxt[i];
    end
  end

  // ---- radians and sin/cos chains: 0 dLat/2, 1 dLon/2, 2 lat1, 3 lat2
  logic signed [RAD_W-1:0] rad_w [0:3];
  logic [1:0]              cos_flip_w;
  cordic_t                 rot_w [0:3][0:N];

  for (genvar g = 0; g < 4; g++) begin : g_trig
    if (g < 2) begin : g_sin
      hgcd_rad u_rad (
        .clk     (clk),
        .en      (en),
        .angle_i (ang_r[g]),
        .rad_o   (rad_w[g]),
        .flip_o  ()
      );
    end else begin : g_cos
      hgcd_rad u_rad (
        .clk     (clk),
        .en      (en),
        .angle_i (ang_r[g]),
        .rad_o   (rad_w[g]),
        .flip_o  (cos_flip_w[g-2])
      );
    end

    assign rot_w[g][0].x = GAIN_INV_Q30;
    assign rot_w[g][0].y = '0;
    assign rot_w[g][0].z = CORDIC_W'(rad_w[g]);

    for (genvar s = 0; s < N; s++) begin : g_cell
      hgcd_cordic_cell #(
        .STAGE     (s),
        .VECTORING (1'b0)
      ) u_cell (
        .clk    (clk),
        .en     (en),
        .cell_i (rot_w[g][s]),
        .cell_o (rot_w[g][s+1])
      );
    end
  end

  // cosine sign fix rides alongside the rotation chain
  logic [1:0] flip_dly_r [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      flip_dly_r[0] <= cos_flip_w;
      for (int i = 1; i < N; i++) flip_dly_r[i] <= flip_dly_r[i-1];
    end
  end

  // ---- a = s1^2 + (c1*c2)*s2^2 in Q60, three product stages and a clamp
  logic signed [TRIG_W-1:0] s1, s2, c1, c2;
  logic signed [63:0]       cc_prod, ss_prod, ws_prod, vs_prod, a_sum;
  logic signed [63:0]       cc_rnd, ws_rnd;
  logic signed [TRIG_W-1:0] w_r, v_r, s2_p1_r, s2_p2_r;
  logic [62:0]              sq_p1_r, sq_p2_r;
  logic [Q60_W-1:0]         a_nxt, a_r, ra_r, rb_r;

  always_comb begin
    s1 = TRIG_W'(rot_w[0][N].y);
    s2 = TRIG_W'(rot_w[1][N].y);
    c1 = flip_dly_r[N-1][0] ? -TRIG_W'(rot_w[2][N].x) : TRIG_W'(rot_w[2][N].x);
    c2 = flip_dly_r[N-1][1] ? -TRIG_W'(rot_w[3][N].x) : TRIG_W'(rot_w[3][N].x);
    cc_prod = 64'(c1) * 64'(c2);
    ss_prod = 64'(s1) * 64'(s1);
    cc_rnd  = (cc_prod + 64'sd536870912) >>> 30;
    ws_prod = 64'(w_r) * 64'(s2_p1_r);
    ws_rnd  = (ws_prod + 64'sd536870912) >>> 30;
    vs_prod = 64'(v_r) * 64'(s2_p2_r);
    a_sum   = $signed({1'b0, sq_p2_r}) + vs_prod;
    if (a_sum[63]) begin
      a_nxt = '0;
    end else if (a_sum > $signed({3'b000, ONE_Q60})) begin
      a_nxt = ONE_Q60;
    end else begin
      a_nxt = a_sum[Q60_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r     <= TRIG_W'(cc_rnd);
      sq_p1_r <= ss_prod[62:0];
      s2_p1_r <= s2;
      v_r     <= TRIG_W'(ws_rnd);
      sq_p2_r <= sq_p1_r;
      s2_p2_r <= s2_p1_r;
      a_r     <= a_nxt;
      ra_r    <= a_r;
      rb_r    <= ONE_Q60 - a_r;
    end
  end

  // ---- sqrt(a) and sqrt(1-a), one result bit per cell
  sqrt_t sq_w [0:1][0:ROOT_W];

  assign sq_w[0][0].rem  = ra_r;
  assign sq_w[0][0].root = '0;
  assign sq_w[1][0].rem  = rb_r;
  assign sq_w[1][0].root = '0;

  for (genvar r = 0; r < 2; r++) begin : g_root
    for (genvar b = 0; b < ROOT_W; b++) begin : g_cell
      hgcd_sqrt_cell #(
        .BIT (ROOT_W - 1 - b)
      ) u_cell (
        .clk    (clk),
        .en     (en),
        .cell_i (sq_w[r][b]),
        .cell_o (sq_w[r][b+1])
      );
    end
  end

  // ---- atan2(sqrt(a), sqrt(1-a)) by vectoring
  cordic_t vec_w [0:N];

  assign vec_w[0].x = CORDIC_W'(sq_w[1][ROOT_W].root);
  assign vec_w[0].y = CORDIC_W'(sq_w[0][ROOT_W].root);
  assign vec_w[0].z = '0;

  for (genvar s = 0; s < N; s++) begin : g_vec
    hgcd_cordic_cell #(
      .STAGE     (s),
      .VECTORING (1'b1)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .cell_i (vec_w[s]),
      .cell_o (vec_w[s+1])
    );
  end

  // ---- distance = round(z * 2R / 2^20), saturated
  logic [CORDIC_W-2:0] z_pos;
  logic [46:0]         dist_prod;
  logic [DIST_W-1:0]   dist_nxt, dist_r;

  always_comb begin
    z_pos     = vec_w[N].z[CORDIC_W-1] ? '0 : vec_w[N].z[CORDIC_W-2:0];
    dist_prod = 47'(z_pos) * 47'(DIAMETER_KM) + 47'd524288;
    dist_nxt  = (dist_prod[46:20] > 27'(DIST_MAX)) ? DIST_MAX : dist_prod[44:20];
  end

  always_ff @(posedge clk) begin
    if (en) dist_r <= dist_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_distance_km = dist_r;

  // ---- checks
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[PIPE_DEPTH-1]) |=> out_valid)
    else $error("word at pipe end did not reach the output register");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid line moved while the pipe was held");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[A_STAGE] |-> (a_r <= ONE_Q60))
    else $error("haversine term escaped its clamp");

endmodule

`default_nettype wire

[verif/haversine_great_circle_distance_top_tb.sv]
// Self-checking testbench for haversine_great_circle_distance_top.
// Drives point pairs, predicts each distance in fixed point and checks it.
// Depends on hgcd_pkg and the top level of the block.
`timescale 1ns / 1ps

module haversine_great_circle_distance_top_tb;
  import hgcd_pkg::*;

  localparam int NITER = (CORDIC_ITERATIONS_DEF > 32) ? 32 : CORDIC_ITERATIONS_DEF;
  localparam int LATENCY = 2 * CORDIC_ITERATIONS_DEF + 43;
  localparam longint FULL = 754974720;
  localparam longint QTR = 188743680;
  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat1;
    logic signed [LON_W-1:0] lon1;
    logic signed [LAT_W-1:0] lat2;
    logic signed [LON_W-1:0] lon2;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [LAT_W-1:0] in_first_latitude = '0;
  logic signed [LON_W-1:0] in_first_longitude = '0;
  logic signed [LAT_W-1:0] in_second_latitude = '0;
  logic signed [LON_W-1:0] in_second_longitude = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance_km;

  haversine_great_circle_distance_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_latitude(in_first_latitude),
    .in_first_longitude(in_first_longitude),
    .in_second_latitude(in_second_latitude),
    .in_second_longitude(in_second_longitude),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance_km(out_distance_km)
  );

  pair_t pending_pairs[$];
  logic [DIST_W-1:0] expected_dist[$];
  int mismatches = 0;
  int send_idle_pct = 0;   // percent of cycles the sender holds off
  int recv_idle_pct = 0;   // percent of cycles the receiver stalls
  int hold_cycles = 0;     // long receiver hold-off counter
  bit hold_go = 0;         // request for the long hold-off
  bit hold_used = 0;
  logic in_stall_q = 1'b0; // stall as seen at the last rising edge

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Predictor: fixed-point haversine, same rounding as the block.
  // ---------------------------------------------------------------
  function automatic longint atan_entry(int i);
    longint tab[32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001,
      64'h0, 64'h0};
    return tab[i];
  endfunction

  // rotation CORDIC on an angle in 2^-21 degree units
  function automatic void rotate_angle(input longint u, output longint s,
                                       output longint c);
    longint r, m, z, x, y, t;
    bit flip;
    r = u % FULL;
    if (r < 0) r += FULL;
    if (r >= FULL / 2) r -= FULL;
    flip = 0;
    if (r > QTR) begin
      r = FULL / 2 - r;
      flip = 1;
    end else if (r < -QTR) begin
      r = -FULL / 2 - r;
      flip = 1;
    end
    m = (r < 0) ? -r : r;
    z = (m * 64'sd1686629713 + QTR / 2) / QTR;
    if (r < 0) z = -z;
    x = 652032874;
    y = 0;
    for (int i = 0; i < NITER; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_entry(i);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_entry(i);
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one >>= 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v -= res + one;
        res = (res >> 1) + one;
      end else res >>= 1;
      one >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [DIST_W-1:0] predict_distance(pair_t p);
    longint la1, lo1, la2, lo2, s1, s2, c1, c2, dm, w, v, a, x, y, z, t, d;
    la1 = p.lat1; lo1 = p.lon1; la2 = p.lat2; lo2 = p.lon2;
    rotate_angle(la2 - la1, s1, dm);
    rotate_angle(lo2 - lo1, s2, dm);
    rotate_angle(2 * la1, dm, c1);
    rotate_angle(2 * la2, dm, c2);
    w = (c1 * c2 + (64'sd1 <<< 29)) >>> 30;
    v = (w * s2 + (64'sd1 <<< 29)) >>> 30;
    a = s1 * s1 + v * s2;
    if (a < 0) a = 0;
    if (a > (64'sd1 <<< 60)) a = 64'sd1 <<< 60;
    y = floor_sqrt(a);
    x = floor_sqrt((64'sd1 <<< 60) - a);
    z = 0;
    for (int i = 0; i < NITER; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_entry(i);
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_entry(i);
      end
    end
    if (z < 0) z = 0;
    d = (z * 12742 + (64'sd1 <<< 19)) >>> 20;
    if (d > 33554431) d = 33554431;
    return d[DIST_W-1:0];
  endfunction

  function automatic longint rand_range(longint lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic pair_t make_pair(longint a, longint b, longint c, longint d);
    pair_t p;
    p.lat1 = LAT_W'(a); p.lon1 = LON_W'(b); p.lat2 = LAT_W'(c); p.lon2 = LON_W'(d);
    return p;
  endfunction

  function automatic void add_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  // ---------------------------------------------------------------
  // Driver: presents the head of pending_pairs, changes at negedge.
  // The word is popped once it was taken at the preceding posedge.
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        expected_dist.insert(expected_dist.size(),
                             predict_distance(pending_pairs.pop_front()));
      end
      if ((!in_valid || !in_stall_q) ) begin
        if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_first_latitude <= pending_pairs[0].lat1;
          in_first_longitude <= pending_pairs[0].lon1;
          in_second_latitude <= pending_pairs[0].lat2;
          in_second_longitude <= pending_pairs[0].lon2;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver side stall, long hold-off counted here
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_go && !hold_used) begin
        hold_used <= 1'b1;
        out_stall <= 1'b1;
        hold_cycles <= 300;
      end else if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) in_stall_q <= in_stall;

  // ---------------------------------------------------------------
  // Monitor: checks each accepted distance against the oldest one.
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected distance word %0d", out_distance_km);
      end else begin
        logic [DIST_W-1:0] want;
        want = expected_dist.pop_front();
        if (want !== out_distance_km) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d actual %0d", want, out_distance_km);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus: directed corners, then random phases.
  // ---------------------------------------------------------------
  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // extremes, identical points, antipodes, poles, out-of-range wrap
    add_pair(make_pair(0, 0, 0, 0));
    add_pair(make_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
    add_pair(make_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
    add_pair(make_pair(0, 0, 0, LON_MAX));
    add_pair(make_pair(0, -LON_MAX / 2, 0, LON_MAX / 2));
    add_pair(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
    add_pair(make_pair(LAT_MAX, 12345, LAT_MAX, -98765));
    add_pair(make_pair(-LAT_MAX, 0, -LAT_MAX, LON_MAX));
    add_pair(make_pair(0, 0, 1, 1));
    add_pair(make_pair(0, 0, -1, -1));
    add_pair(make_pair(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1));
    add_pair(make_pair((1 << 27) - 1, (1 << 28) - 1, -(1 << 27), -(1 << 28)));
    add_pair(make_pair((1 << 27) - 1, 0, (1 << 27) - 1, 0));
    add_pair(make_pair(-(1 << 27), 0, 0, 0));
    add_pair(make_pair(40 << 20, -74 << 20, 51 << 20, 0));
    add_pair(make_pair(-33 << 20, 151 << 20, 35 << 20, 139 << 20));
    add_pair(make_pair(0, 179 << 20, 0, -179 << 20));
    add_pair(make_pair(0, 0, 0, 180 << 20));
    add_pair(make_pair(LAT_MAX - 1, 0, 1 - LAT_MAX, 1));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 32 : 0;
      for (int k = 0; k < 180; k++) begin
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6)
          add_pair(make_pair(rand_range(LAT_MAX), rand_range(LON_MAX),
                             rand_range(LAT_MAX), rand_range(LON_MAX)));
        else if (kind < 8) begin
          // nearby points: tiny a
          longint la, lo;
          la = rand_range(LAT_MAX);
          lo = rand_range(LON_MAX);
          add_pair(make_pair(la, lo, la + rand_range(64), lo + rand_range(64)));
        end else
          // raw bit patterns, out of range included
          add_pair(make_pair($urandom(), $urandom(), $urandom(), $urandom()));
      end
      if (phase == 2) begin
        // long receiver hold-off while the sender keeps offering words
        @(negedge clk);
        hold_go = 1'b1;
      end
      wait_drained();
    end

    while (expected_dist.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && expected_dist.size() == 0) begin
      $display("** haversine_great_circle_distance_top: PASSED **");
    end else begin
      $display("** haversine_great_circle_distance_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("** haversine_great_circle_distance_top: FAILED **");
    $finish;
  end

endmodule

[sim.f]
src/hgcd_pkg.sv
src/hgcd_rad.sv
src/hgcd_cordic_cell.sv
src/hgcd_sqrt_cell.sv
src/haversine_great_circle_distance_top.sv
verif/haversine_great_circle_distance_top_tb.sv
